### sv/aes_pkg.sv
// shared types, constants and round functions for the aes block cipher
package aes_pkg;

	localparam int NB_COLS    = 4;
	localparam int MAX_ROUNDS = 14;
	localparam int RK_WORDS   = NB_COLS * (MAX_ROUNDS + 1);
	localparam logic [7:0] GF_POLY = 8'h1b;

	typedef enum logic [1:0] {
		KL_128 = 2'd0,
		KL_192 = 2'd1,
		KL_256 = 2'd2,
		KL_RSV = 2'd3
	} key_len_t;

	typedef enum logic [2:0] {
		REG_KEY_LEN = 3'd0,
		REG_KEY_0_7 = 3'd1,
		REG_KEY_8_15 = 3'd2,
		REG_KEY_16_23 = 3'd3,
		REG_KEY_24_31 = 3'd4
	} reg_idx_t;

	// per-cell round control
	typedef struct packed {
		logic bypass;
		logic last;
	} rnd_ctrl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// byte i of the state sits at bits 127-8i downwards
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127-8*(4*c+r) -: 8] = SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, all;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127-32*c -: 8];
			a1 = s[119-32*c -: 8];
			a2 = s[111-32*c -: 8];
			a3 = s[103-32*c -: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			t[127-32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[119-32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[111-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[103-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

endpackage

### sv/aes_key_exp.sv
// key schedule sequencer: one round-key word per cycle into a word store
module aes_key_exp
	import aes_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  key_len_t     mode,
	input  logic [255:0] key,
	output logic         busy,
	output logic [127:0] rkeys [MAX_ROUNDS+1]
);

	logic [31:0] rkw_q [RK_WORDS];
	logic [31:0] win_q [8];
	logic [5:0]  idx_q;
	logic [2:0]  phase_q;
	logic [7:0]  rcon_q;
	logic        load_q;
	logic        busy_q;

	logic [31:0] kw [8];
	logic [31:0] tmp, src, nw;
	logic [2:0]  nk_m1;
	logic [5:0]  last_idx;
	logic [5:0]  nk;

	always_comb begin
		for (int j = 0; j < 8; j++) kw[j] = key[255-32*j -: 32];
		case (mode)
			KL_128: begin
				nk_m1 = 3'd3; last_idx = 6'd43; nk = 6'd4; src = win_q[4];
			end
			KL_192: begin
				nk_m1 = 3'd5; last_idx = 6'd51; nk = 6'd6; src = win_q[2];
			end
			default: begin
				nk_m1 = 3'd7; last_idx = 6'd59; nk = 6'd8; src = win_q[0];
			end
		endcase
		tmp = win_q[7];
		if (phase_q == 3'd0) begin
			tmp = sub_word({win_q[7][23:0], win_q[7][31:24]}) ^ {rcon_q, 24'h0};
		end else if (nk_m1 == 3'd7 && phase_q == 3'd4) begin
			tmp = sub_word(win_q[7]);
		end
		nw = src ^ tmp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= 1'b1;
			busy_q <= 1'b1;
		end else if (start) begin
			load_q <= 1'b1;
			busy_q <= 1'b1;
		end else if (load_q) begin
			load_q <= 1'b0;
		end else if (busy_q && idx_q == last_idx) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_q) begin
			for (int j = 0; j < 8; j++) rkw_q[j] <= kw[j];
			// newest key word at the top of the window
			for (int j = 0; j < 8; j++) begin
				win_q[j] <= (j >= 8 - int'(nk)) ? kw[j - 8 + int'(nk)] : 32'h0;
			end
			idx_q   <= nk;
			phase_q <= 3'd0;
			rcon_q  <= 8'h01;
		end else if (busy_q) begin
			rkw_q[idx_q] <= nw;
			for (int j = 0; j < 7; j++) win_q[j] <= win_q[j+1];
			win_q[7] <= nw;
			idx_q    <= idx_q + 6'd1;
			phase_q  <= (phase_q == nk_m1) ? 3'd0 : phase_q + 3'd1;
			if (phase_q == 3'd0) rcon_q <= xtime(rcon_q);
		end
	end

	always_comb begin
		for (int r = 0; r <= MAX_ROUNDS; r++) begin
			rkeys[r] = {rkw_q[4*r], rkw_q[4*r+1], rkw_q[4*r+2], rkw_q[4*r+3]};
		end
	end

	assign busy = busy_q;

endmodule

### sv/aes_rnd_cell.sv
// one cipher round cell of the pipeline chain
module aes_rnd_cell
	import aes_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  logic [127:0] in_state,
	input  logic [127:0] rkey,
	input  rnd_ctrl_t    ctrl,
	output logic         out_valid,
	output logic [127:0] out_state
);

	logic         valid_q;
	logic [127:0] state_q;
	logic [127:0] ss, nxt;

	always_comb begin
		ss = sub_shift(in_state);
		if (ctrl.bypass) nxt = in_state;
		else if (ctrl.last) nxt = ss ^ rkey;
		else nxt = mix_cols(ss) ^ rkey;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (en) valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) state_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_state = state_q;

endmodule

### sv/aes_block_encrypt.sv
// aes block encryption top level: key registers, key schedule and round chain
//
//  channel  | dir | fields                                  | handshake
//  s_*      | in  | tdata: plain_high, plain_low            | s_tvalid / s_tready
//  m_*      | out | tdata: cipher_high, cipher_low          | m_tvalid / m_tready
//  apb      | in  | key_length, key bytes (64-bit regs)     | psel, penable, pready
//
// one request per cycle sustained while the output is accepted; stages: initial key add, then
// fourteen round cells; rounds beyond the key length pass the state through
// after reset and after every register write the key schedule runs one word
// per cycle; s_tready stays low meanwhile
// the whole chain stalls together while the output holds an unaccepted result
module aes_block_encrypt
	import aes_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// apb register port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	// plaintext stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // [63:0] plain_high, [127:64] plain_low
	// ciphertext stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata    // [63:0] cipher_high, [127:64] cipher_low
);

	// configuration registers
	logic [1:0]  key_len_q;
	logic [63:0] key_q [4];
	logic        cfg_wr;
	reg_idx_t    cfg_idx;
	key_len_t    mode;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= 2'd0;
			for (int j = 0; j < 4; j++) key_q[j] <= 64'h0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_KEY_LEN:   key_len_q <= pwdata[1:0];
				REG_KEY_0_7:   key_q[0] <= pwdata;
				REG_KEY_8_15:  key_q[1] <= pwdata;
				REG_KEY_16_23: key_q[2] <= pwdata;
				REG_KEY_24_31: key_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_KEY_LEN:   prdata = {62'h0, key_len_q};
			REG_KEY_0_7:   prdata = key_q[0];
			REG_KEY_8_15:  prdata = key_q[1];
			REG_KEY_16_23: prdata = key_q[2];
			REG_KEY_24_31: prdata = key_q[3];
			default:       prdata = 64'h0;
		endcase
	end

	// reserved length code behaves as a 256-bit key
	assign mode = (key_len_q == KL_RSV) ? KL_256 : key_len_t'(key_len_q);

	// key schedule
	logic         ks_busy;
	logic [127:0] rkeys [MAX_ROUNDS+1];

	aes_key_exp u_key_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_wr),
		.mode   (mode),
		.key    ({key_q[0], key_q[1], key_q[2], key_q[3]}),
		.busy   (ks_busy),
		.rkeys  (rkeys)
	);

	// chain advances unless the output holds a result not yet taken
	logic en;
	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en & ~ks_busy;

	// number of rounds: 10, 12 or 14
	logic [3:0] nr;
	always_comb begin
		case (mode)
			KL_128:  nr = 4'd10;
			KL_192:  nr = 4'd12;
			default: nr = 4'd14;
		endcase
	end

	// stage zero: initial key addition on the state in byte order 0..15
	logic         vld [MAX_ROUNDS+1];
	logic [127:0] st  [MAX_ROUNDS+1];
	logic         v0_q;
	logic [127:0] st0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v0_q <= 1'b0;
		else if (en) v0_q <= s_tvalid & s_tready;
	end

	always_ff @(posedge clk) begin
		if (en) st0_q <= {s_tdata[63:0], s_tdata[127:64]} ^ rkeys[0];
	end

	assign vld[0] = v0_q;
	assign st[0]  = st0_q;

	// row of round cells
	for (genvar k = 1; k <= MAX_ROUNDS; k++) begin : g_cell
		rnd_ctrl_t ctrl;
		assign ctrl.bypass = (4'(k) > nr);
		assign ctrl.last   = (4'(k) == nr);

		aes_rnd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vld[k-1]),
			.in_state  (st[k-1]),
			.rkey      (rkeys[k]),
			.ctrl      (ctrl),
			.out_valid (vld[k]),
			.out_state (st[k])
		);
	end

	assign m_tvalid = vld[MAX_ROUNDS];
	assign m_tdata  = {st[MAX_ROUNDS][63:0], st[MAX_ROUNDS][127:64]};

endmodule

### sv/aes_block_encrypt_chk.sv
// port-level checker for the aes block encryption top level
module aes_block_encrypt_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         psel,
	input logic         penable,
	input logic         pwrite,
	input logic         pready,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_wr_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite) |=> !s_tready)
		else $error("input taken while key schedule restarts");

	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input taken while chain stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind aes_block_encrypt aes_block_encrypt_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.pready   (pready),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
